// ----- sv/pwmdc_pkg.sv -----
// Shared constants and codes for the three-phase PWM duty capture block.
package pwmdc_pkg;

    // Item kinds on the input channel.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Period assumed for every channel until its first rise is seen.
    localparam int unsigned RESET_PERIOD = 24000;

    // Fixed widths of the result fields.
    localparam int DUTY_W = 16;
    localparam int CH_W   = 2;

endpackage

// ----- sv/pwmdc_capture.sv -----
// Edge timing per channel: time counter, rise time, period and high time.
module pwmdc_capture #(
    parameter int COUNT_BITS = 32,
    parameter int PHASES     = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tick,
    input  logic                       level_a,
    input  logic                       level_b,
    input  logic                       level_c,
    input  logic [pwmdc_pkg::CH_W-1:0] query_channel,
    output logic [COUNT_BITS-1:0]      sel_period,
    output logic [COUNT_BITS-1:0]      sel_high,
    output logic [COUNT_BITS-1:0]      sel_elapsed,
    output logic                       sel_level,
    output logic                       sel_ok
);
    import pwmdc_pkg::*;

    logic [COUNT_BITS-1:0] time_reg, time_next;
    logic [COUNT_BITS-1:0] rise_reg   [PHASES];
    logic [COUNT_BITS-1:0] rise_next  [PHASES];
    logic [COUNT_BITS-1:0] period_reg [PHASES];
    logic [COUNT_BITS-1:0] period_next[PHASES];
    logic [COUNT_BITS-1:0] high_reg   [PHASES];
    logic [COUNT_BITS-1:0] high_next  [PHASES];
    logic [COUNT_BITS-1:0] diff       [PHASES];
    logic [PHASES-1:0]     prev_reg, prev_next;
    logic [PHASES-1:0]     cur;
    logic [COUNT_BITS-1:0] sel_rise;

    // Only the first three channels have a pin; the rest sample low.
    for (genvar g = 0; g < PHASES; g++) begin : g_level
        if (g == 0) begin : g_a
            assign cur[g] = level_a;
        end else if (g == 1) begin : g_b
            assign cur[g] = level_b;
        end else if (g == 2) begin : g_c
            assign cur[g] = level_c;
        end else begin : g_none
            assign cur[g] = 1'b0;
        end
    end

    assign time_next = tick ? time_reg + 1'b1 : time_reg;

    always_comb
    begin
        for (int i = 0; i < PHASES; i++)
        begin
            // An edge is stamped with the counter value after this tick.
            diff[i]        = time_next - rise_reg[i];
            rise_next[i]   = rise_reg[i];
            period_next[i] = period_reg[i];
            high_next[i]   = high_reg[i];
            prev_next[i]   = prev_reg[i];
            if (tick)
            begin
                prev_next[i] = cur[i];
                if (cur[i] != prev_reg[i])
                begin
                    if (cur[i])
                    begin
                        period_next[i] = diff[i];
                        rise_next[i]   = time_next;
                    end
                    else
                    begin
                        high_next[i] = diff[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
            prev_reg <= '0;
            for (int i = 0; i < PHASES; i++)
            begin
                rise_reg[i]   <= '0;
                period_reg[i] <= COUNT_BITS'(RESET_PERIOD);
                high_reg[i]   <= '0;
            end
        end
        else
        begin
            time_reg <= time_next;
            prev_reg <= prev_next;
            for (int i = 0; i < PHASES; i++)
            begin
                rise_reg[i]   <= rise_next[i];
                period_reg[i] <= period_next[i];
                high_reg[i]   <= high_next[i];
            end
        end
    end

    // Channel selection for a query.
    always_comb
    begin
        sel_period = period_reg[0];
        sel_high   = high_reg[0];
        sel_rise   = rise_reg[0];
        sel_level  = prev_reg[0];
        for (int i = 0; i < PHASES; i++)
        begin
            if (i < (1 << CH_W) && query_channel == CH_W'(i))
            begin
                sel_period = period_reg[i];
                sel_high   = high_reg[i];
                sel_rise   = rise_reg[i];
                sel_level  = prev_reg[i];
            end
        end
    end

    assign sel_elapsed = time_reg - sel_rise;
    assign sel_ok      = int'(query_channel) < PHASES;

endmodule

// ----- sv/pwmdc_divider.sv -----
// Bit-serial fractional divider: one quotient bit per cycle into a shift register.
module pwmdc_divider #(
    parameter int COUNT_BITS     = 32,
    parameter int DUTY_FRAC_BITS = 15
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [COUNT_BITS-1:0]     num,
    input  logic [COUNT_BITS-1:0]     den,
    output logic [DUTY_FRAC_BITS-1:0] quot,
    output logic                      done
);
    localparam int CW = $clog2(DUTY_FRAC_BITS + 1);

    logic [COUNT_BITS-1:0]     rem_reg, rem_next;
    logic [COUNT_BITS-1:0]     den_reg, den_next;
    logic [DUTY_FRAC_BITS-1:0] quot_reg, quot_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [COUNT_BITS:0]       two_rem;
    logic [COUNT_BITS:0]       sub;
    logic                      ge;

    // The remainder stays below the divisor, so doubling needs one extra bit.
    assign two_rem = {rem_reg, 1'b0};
    assign sub     = two_rem - {1'b0, den_reg};
    assign ge      = two_rem >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            cnt_next  = CW'(DUTY_FRAC_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? sub[COUNT_BITS-1:0] : two_rem[COUNT_BITS-1:0];
            quot_next = {quot_reg[DUTY_FRAC_BITS-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

// ----- sv/three_phase_pwm_duty_capture.sv -----
// Top level of the three-phase PWM duty capture block.
// Ticks are accepted every cycle while no query is open.
// A query answered by the stuck, zero-period or full-duty rules is decided in S_EVAL
// and its result registered; one that needs division first runs through the
// bit-serial divider. Either result waits while a held result blocks the output.
// Asynchronous active-low reset clears all timing state; periods reset to 24000 ticks.
module three_phase_pwm_duty_capture #(
    parameter int COUNT_BITS     = 32,
    parameter int PHASES         = 3,
    parameter int DUTY_FRAC_BITS = 15
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         kind,
    input  logic                         level_a,
    input  logic                         level_b,
    input  logic                         level_c,
    input  logic [pwmdc_pkg::CH_W-1:0]   query_channel,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [pwmdc_pkg::DUTY_W-1:0] duty_ratio,
    output logic                         stuck_flag,
    output logic [pwmdc_pkg::CH_W-1:0]   answered_channel
);
    import pwmdc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_HOLD = 2'd3;

    localparam int DW = (DUTY_FRAC_BITS + 1 > DUTY_W) ? DUTY_FRAC_BITS + 1 : DUTY_W;

    logic [1:0]                state_reg, state_next;
    logic                      rvalid_reg, rvalid_next;
    logic [DUTY_W-1:0]         duty_reg, duty_next;
    logic                      stuck_reg, stuck_next;
    logic [CH_W-1:0]           chan_reg, chan_next;
    logic [COUNT_BITS-1:0]     period_reg, high_reg, elapsed_reg;
    logic                      level_reg;
    logic [CH_W-1:0]           qch_reg;

    logic                      accept, tick, query_ok;
    logic                      out_free;
    logic [COUNT_BITS-1:0]     sel_period, sel_high, sel_elapsed;
    logic                      sel_level, sel_ok;
    logic                      div_start, div_done;
    logic [DUTY_FRAC_BITS-1:0] quot;
    logic [DW-1:0]             full_w, quot_w;
    logic [DUTY_W-1:0]         full16, quot16;
    logic                      is_stuck, is_zero, is_full;

    // A new item waits while a query is open; a query only finishes once the
    // result register is free, so a held result never blocks ticks by itself.
    assign item_stall = (state_reg != S_IDLE);
    assign out_free   = !rvalid_reg || !result_stall;
    assign accept     = item_valid && !item_stall;
    assign tick       = accept && (kind == KIND_TICK);
    assign query_ok   = accept && (kind == KIND_QUERY) && sel_ok;

    pwmdc_capture #(
        .COUNT_BITS (COUNT_BITS),
        .PHASES     (PHASES)
    ) u_capture (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick          (tick),
        .level_a       (level_a),
        .level_b       (level_b),
        .level_c       (level_c),
        .query_channel (query_channel),
        .sel_period    (sel_period),
        .sel_high      (sel_high),
        .sel_elapsed   (sel_elapsed),
        .sel_level     (sel_level),
        .sel_ok        (sel_ok)
    );

    pwmdc_divider #(
        .COUNT_BITS     (COUNT_BITS),
        .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (high_reg),
        .den   (period_reg),
        .quot  (quot),
        .done  (div_done)
    );

    // Full scale and quotient are cut to the 16-bit result field.
    assign full_w = DW'(1) << DUTY_FRAC_BITS;
    assign quot_w = DW'(quot);
    assign full16 = full_w[DUTY_W-1:0];
    assign quot16 = quot_w[DUTY_W-1:0];

    // Stuck when the time since the last rise exceeds two full periods.
    assign is_stuck = {1'b0, elapsed_reg} > {period_reg, 1'b0};
    assign is_zero  = period_reg == '0;
    assign is_full  = high_reg >= period_reg;

    always_comb
    begin
        state_next  = state_reg;
        rvalid_next = rvalid_reg && result_stall;
        duty_next   = duty_reg;
        stuck_next  = stuck_reg;
        chan_next   = chan_reg;
        div_start   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (query_ok)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!is_stuck && !is_zero && !is_full)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else if (out_free)
                begin
                    chan_next   = qch_reg;
                    stuck_next  = 1'b0;
                    rvalid_next = 1'b1;
                    state_next  = S_IDLE;
                    if (is_stuck)
                    begin
                        duty_next  = level_reg ? full16 : '0;
                        stuck_next = 1'b1;
                    end
                    else if (is_zero)
                    begin
                        duty_next = '0;
                    end
                    else
                    begin
                        duty_next = full16;
                    end
                end
            end
            S_DIV, S_HOLD:
            begin
                // The quotient stays in the divider until the result register frees up.
                if (state_reg == S_HOLD || div_done)
                begin
                    if (out_free)
                    begin
                        chan_next   = qch_reg;
                        stuck_next  = 1'b0;
                        duty_next   = quot16;
                        rvalid_next = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        duty_reg  <= duty_next;
        stuck_reg <= stuck_next;
        chan_reg  <= chan_next;
        if (query_ok)
        begin
            period_reg  <= sel_period;
            high_reg    <= sel_high;
            elapsed_reg <= sel_elapsed;
            level_reg   <= sel_level;
            qch_reg     <= query_channel;
        end
    end

    assign result_valid     = rvalid_reg;
    assign duty_ratio       = duty_reg;
    assign stuck_flag       = stuck_reg;
    assign answered_channel = chan_reg;

endmodule

// ----- sv/pwmdc_checker.sv -----
// Port-level checker for the duty capture block and its bind to the top level.
module pwmdc_checker #(
    parameter int PHASES         = 3,
    parameter int DUTY_FRAC_BITS = 15
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_stall,
    input logic                         kind,
    input logic [pwmdc_pkg::CH_W-1:0]   query_channel,
    input logic                         result_valid,
    input logic                         result_stall,
    input logic [pwmdc_pkg::DUTY_W-1:0] duty_ratio,
    input logic                         stuck_flag,
    input logic [pwmdc_pkg::CH_W-1:0]   answered_channel
);
    import pwmdc_pkg::*;

    localparam logic [31:0] FULL = 32'd1 << DUTY_FRAC_BITS;

    // A held result keeps its payload until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(duty_ratio) && $stable(stuck_flag)
            && $stable(answered_channel))
        else $error("result changed while stalled");

    // A query for an existing channel closes the input until it is answered.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && kind == KIND_QUERY
            && int'(query_channel) < PHASES |=> item_stall)
        else $error("input open right after a query");

    a_channel: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> int'(answered_channel) < PHASES)
        else $error("result names a missing channel");

    // A stuck channel reports only the two extremes.
    a_stuck: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && stuck_flag |->
            duty_ratio == '0 || 32'(duty_ratio) == (FULL & 32'hFFFF))
        else $error("stuck result not at an extreme");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> DUTY_FRAC_BITS > 15 || 32'(duty_ratio) <= FULL)
        else $error("duty above full scale");

endmodule

bind three_phase_pwm_duty_capture pwmdc_checker #(
    .PHASES         (PHASES),
    .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
) u_pwmdc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .kind             (kind),
    .query_channel    (query_channel),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .duty_ratio       (duty_ratio),
    .stuck_flag       (stuck_flag),
    .answered_channel (answered_channel)
);
